FILE: rtl/ppfr_pkg.sv
// Shared types and constants for the pulse pair frame receiver.
package ppfr_pkg;

  localparam int SYMBOLS_PER_FRAME = 4;
  localparam int COUNT_WIDTH       = 16;
  localparam int SYM_IDX_W         = (SYMBOLS_PER_FRAME > 1) ? $clog2(SYMBOLS_PER_FRAME) : 1;
  localparam int OUT_SYMBOLS       = 4;
  localparam int OUT_TDATA_W       = 16;
  localparam int IN_TDATA_W        = 8;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;

  localparam logic [COUNT_WIDTH-1:0] SLOT_TICKS_RESET   = COUNT_WIDTH'(1250);
  localparam logic [COUNT_WIDTH-1:0] START_WINDOW_RESET = COUNT_WIDTH'(4250);

  // register indexes (paddr[2])
  localparam logic REG_SLOT_TICKS   = 1'b0;
  localparam logic REG_START_WINDOW = 1'b1;

  localparam logic [1:0] SYM_ZERO    = 2'd0;
  localparam logic [1:0] SYM_ONE     = 2'd1;
  localparam logic [1:0] SYM_INVALID = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DISCARD = 1'b1;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] slot_ticks;
    logic [COUNT_WIDTH-1:0] start_window_ticks;
  } ppfr_cfg_t;

  typedef struct packed {
    logic [OUT_SYMBOLS-1:0][1:0] symbol;
    logic                        frame_status;
  } ppfr_result_t;

endpackage

FILE: rtl/ppfr_cfg_regs.sv
// APB register file holding slot and start window lengths.
module ppfr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppfr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ppfr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ppfr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output ppfr_pkg::ppfr_cfg_t            cfg
);
  import ppfr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_ticks         <= SLOT_TICKS_RESET;
      cfg.start_window_ticks <= START_WINDOW_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SLOT_TICKS:   cfg.slot_ticks         <= pwdata[COUNT_WIDTH-1:0];
        REG_START_WINDOW: cfg.start_window_ticks <= pwdata[COUNT_WIDTH-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SLOT_TICKS:   prdata[COUNT_WIDTH-1:0] = cfg.slot_ticks;
      REG_START_WINDOW: prdata[COUNT_WIDTH-1:0] = cfg.start_window_ticks;
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/ppfr_frame_fsm.sv
// Frame sequencer: start window, symbol slots, stop check and result build.
module ppfr_frame_fsm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   acc,
  input  logic                   line_sample,
  input  ppfr_pkg::ppfr_cfg_t    cfg,
  output logic                   res_valid,
  output ppfr_pkg::ppfr_result_t res
);
  import ppfr_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_SYM_A  = 3'd2;
  localparam logic [2:0] PH_SYM_B  = 3'd3;
  localparam logic [2:0] PH_STOP_A = 3'd4;
  localparam logic [2:0] PH_STOP_B = 3'd5;

  localparam logic [SYM_IDX_W-1:0] LAST_IDX = SYM_IDX_W'(SYMBOLS_PER_FRAME - 1);

  logic [2:0]             phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [SYM_IDX_W-1:0]   symbol_index, symbol_index_next;
  logic                   first_slot_high, first_slot_high_next;
  logic                   slot_high_seen, slot_high_seen_next;
  logic                   stop_ok, stop_ok_next;
  logic [1:0]             symbol_store [SYMBOLS_PER_FRAME];

  logic [COUNT_WIDTH-1:0] slot_len;
  logic [COUNT_WIDTH-1:0] start_end;
  logic [COUNT_WIDTH:0]   tick_inc;
  logic                   slot_done;
  logic                   start_done;
  logic                   start_abort;
  logic                   seen_now;
  logic                   sym_we;
  logic [1:0]             sym;
  logic                   emit_status;

  assign slot_len   = (cfg.slot_ticks == '0) ? COUNT_WIDTH'(1) : cfg.slot_ticks;
  assign start_end  = (cfg.start_window_ticks > slot_len) ? cfg.start_window_ticks : slot_len;
  assign tick_inc   = {1'b0, tick_count} + (COUNT_WIDTH+1)'(1);
  assign slot_done  = tick_inc >= {1'b0, slot_len};
  assign start_done = tick_inc >= {1'b0, start_end};
  assign start_abort = line_sample && (tick_count >= slot_len) &&
                       (tick_count < cfg.start_window_ticks);
  assign seen_now   = slot_high_seen | line_sample;

  always_comb begin
    if (first_slot_high && seen_now)        sym = SYM_ONE;
    else if (!first_slot_high && !seen_now) sym = SYM_ZERO;
    else                                     sym = SYM_INVALID;
  end

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    symbol_index_next    = symbol_index;
    first_slot_high_next = first_slot_high;
    slot_high_seen_next  = slot_high_seen;
    stop_ok_next         = stop_ok;
    sym_we               = 1'b0;
    res_valid            = 1'b0;
    emit_status          = STATUS_DISCARD;
    if (acc) begin
      unique case (phase)
        PH_IDLE, PH_START: begin
          if (phase == PH_START && start_abort) begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end else if (phase == PH_START || line_sample) begin
            if (start_done) begin
              symbol_index_next   = '0;
              phase_next          = PH_SYM_A;
              tick_count_next     = '0;
              slot_high_seen_next = 1'b0;
            end else begin
              phase_next      = PH_START;
              tick_count_next = tick_inc[COUNT_WIDTH-1:0];
            end
          end
        end
        PH_SYM_A: begin
          if (slot_done) begin
            first_slot_high_next = seen_now;
            phase_next           = PH_SYM_B;
            tick_count_next      = '0;
            slot_high_seen_next  = 1'b0;
          end else begin
            tick_count_next     = tick_inc[COUNT_WIDTH-1:0];
            slot_high_seen_next = seen_now;
          end
        end
        PH_SYM_B: begin
          if (slot_done) begin
            sym_we              = 1'b1;
            tick_count_next     = '0;
            slot_high_seen_next = 1'b0;
            if (symbol_index == LAST_IDX) begin
              stop_ok_next = 1'b0;
              phase_next   = PH_STOP_A;
            end else begin
              symbol_index_next = symbol_index + SYM_IDX_W'(1);
              phase_next        = PH_SYM_A;
            end
          end else begin
            tick_count_next     = tick_inc[COUNT_WIDTH-1:0];
            slot_high_seen_next = seen_now;
          end
        end
        PH_STOP_A: begin
          if (line_sample) stop_ok_next = 1'b1;
          if (slot_done) begin
            phase_next          = PH_STOP_B;
            tick_count_next     = '0;
            slot_high_seen_next = 1'b0;
          end else begin
            tick_count_next = tick_inc[COUNT_WIDTH-1:0];
          end
        end
        PH_STOP_B: begin
          if (line_sample || slot_done) begin
            res_valid   = 1'b1;
            emit_status = (!line_sample && stop_ok) ? STATUS_OK : STATUS_DISCARD;
            phase_next           = PH_IDLE;
            tick_count_next      = '0;
            symbol_index_next    = '0;
            slot_high_seen_next  = 1'b0;
            first_slot_high_next = 1'b0;
            stop_ok_next         = 1'b0;
          end else begin
            tick_count_next = tick_inc[COUNT_WIDTH-1:0];
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    res.frame_status = emit_status;
    for (int k = 0; k < OUT_SYMBOLS; k++) begin
      res.symbol[k] = (k < SYMBOLS_PER_FRAME) ? symbol_store[k] : SYM_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= '0;
      symbol_index    <= '0;
      first_slot_high <= 1'b0;
      slot_high_seen  <= 1'b0;
      stop_ok         <= 1'b0;
    end else begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      symbol_index    <= symbol_index_next;
      first_slot_high <= first_slot_high_next;
      slot_high_seen  <= slot_high_seen_next;
      stop_ok         <= stop_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_we) symbol_store[symbol_index] <= sym;
  end

  a_emit_to_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> phase == PH_IDLE)
    else $error("phase not idle after frame result");

  a_emit_from_stop: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (phase == PH_STOP_B && acc))
    else $error("frame result outside second stop slot");

  a_stop_ok_src: assert property (@(posedge clk) disable iff (rst)
    $rose(stop_ok) |-> $past(phase) == PH_STOP_A)
    else $error("stop flag set outside first stop slot");

endmodule

FILE: rtl/ppfr_out_buf.sv
// Two-entry output register with skid stage on the result stream.
module ppfr_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ppfr_pkg::ppfr_result_t push_data,
  output logic                   space,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output ppfr_pkg::ppfr_result_t out_data
);
  import ppfr_pkg::*;

  logic         out_valid;
  logic         skid_valid;
  ppfr_result_t skid_data;
  logic         pop;

  assign pop      = out_valid & m_tready;
  assign space    = ~skid_valid;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid && !pop) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && pop) begin
      out_data <= skid_data;
    end else if (push && !skid_valid && (!out_valid || pop)) begin
      out_data <= push_data;
    end
    if (push && !skid_valid && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (out_valid && !skid_valid))
    else $error("skid entry lost on drain");

endmodule

FILE: rtl/pulse_pair_frame_receiver.sv
// Pulse pair frame receiver top level.
//
// Usage: one line sample per request on the s_ channel (s_tdata[0], 1 = pulse).
// Samples are taken one per clock while s_tready is high; the frame sequencer
// advances once per accepted sample, so timing is counted in accepted samples,
// not clocks. A frame starts on a high sample in idle, runs the start quiet
// window, four two-slot symbols and a two-slot stop check, then produces one
// request on the m_ channel with the symbols and a status bit.
// Results are registered as the frame's final sample is accepted: into the
// output register if free or draining, else into the skid stage. Throughput:
// one sample per clock while s_tready is high, set by the single registered
// pass of the sequencer; the skid stage keeps s_tready up while a result waits.
// When the receiver stalls, up to two results are held; s_tready drops
// only when both are full and returns as soon as one is taken.
// Reset (rst, synchronous) returns the sequencer to idle, empties the
// result buffer and loads slot_ticks = 1250 and start_window_ticks = 4250.
// Registers via APB: slot_ticks at 0x0, start_window_ticks at 0x4.
module pulse_pair_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ppfr_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] line_sample
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ppfr_pkg::OUT_TDATA_W-1:0] m_tdata,   // [0] frame_status, [2:1] symbol_0,
                                                      // [4:3] symbol_1, [6:5] symbol_2,
                                                      // [8:7] symbol_3
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppfr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ppfr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ppfr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import ppfr_pkg::*;

  ppfr_cfg_t    cfg;
  ppfr_result_t res;
  ppfr_result_t out_data;
  logic         res_valid;
  logic         space;
  logic         acc;

  assign s_tready = space;
  assign acc      = s_tvalid & s_tready;
  assign m_tdata  = {(OUT_TDATA_W - $bits(ppfr_result_t))'(0), out_data};

  ppfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppfr_frame_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .line_sample (s_tdata[0]),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  ppfr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_data  (out_data)
  );

endmodule
